/* hdl/mlcf_pkg.sv */
// Shared types and codes for the multi-LED color fader.
`timescale 1ns / 1ps

package mlcf_pkg;

  // Request kinds carried in the input tuser field.
  typedef enum logic [1:0] {
    REQ_TICK    = 2'd0,
    REQ_ENABLE  = 2'd1,
    REQ_CHANNEL = 2'd2,
    REQ_DEFAULT = 2'd3
  } req_e;

  // Enable modes; every other code toggles.
  localparam logic [1:0] EN_OFF = 2'd0;
  localparam logic [1:0] EN_ON  = 2'd1;

  // Target channel selectors; the unused code makes a channel write do nothing.
  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;
  localparam logic [1:0] CH_NONE  = 2'd3;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_SCAN = 1'b1
  } state_e;

  // Controller to datapath.
  typedef struct packed {
    logic       apply_req;  // a non-tick request is accepted this cycle
    logic       step_en;    // step the device at idx and load the output
    logic [2:0] idx;        // device visited by the tick scan
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic [3:0] n_active;    // device count clipped to the device number
    logic       cur_fading;  // device at idx is fading
    logic       out_free;    // output register can take a beat this cycle
  } status_t;

endpackage

/* hdl/multi_led_color_fader_core.sv */
// Top level of the multi-LED color fader: stream ports, controller and datapath.
`timescale 1ns / 1ps

// Channel   Direction  Beat contents
// -------   ---------  ---------------------------------------------------------
// cfg       in         cfg_data_i: device_count (4 bits)
// s_axis    in         tuser: req_type; tdata: device_index, enable_mode, channel,
//                      channel_value, default_rgb (low bits first)
// m_axis    out        tdata: out_device, out_red, out_green, out_blue; tlast: out_last
//
// A non-tick request is applied at the edge that accepts it. A tick is accepted
// first, and then the scan visits each active device in turn; the scan stalls only
// while a fading device finds the single output register still holding an
// unaccepted beat, and no beat is lost.
// Reset clears every device to black, disabled and not fading, and the count to 0.
// Configuration writes are always accepted and are meant to land while idle.

module multi_led_color_fader_core #(
  parameter int DEVICES = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [3:0]  cfg_data_i,      // device_count

  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,    // [2:0] device_index, [4:3] enable_mode,
                                       // [6:5] channel, [14:7] channel_value,
                                       // [38:15] default_rgb, [39] zero fill
  input  logic [1:0]  s_axis_tuser,    // [1:0] req_type

  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,    // [2:0] out_device, [10:3] out_red,
                                       // [18:11] out_green, [26:19] out_blue,
                                       // [31:27] zero fill
  output logic        m_axis_tlast     // out_last
);
  import mlcf_pkg::*;

  cmd_t        cmd;
  status_t     status;
  logic        in_tick;
  logic [2:0]  out_device;
  logic [7:0]  out_red, out_green, out_blue;

  // The count register is a plain write; nothing ever holds it back.
  assign cfg_ready_o = 1'b1;

  assign in_tick = (req_e'(s_axis_tuser) == REQ_TICK);

  mlcf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_tick_i  (in_tick),
    .status_i   (status),
    .in_ready_o (s_axis_tready),
    .cmd_o      (cmd)
  );

  mlcf_dp #(
    .DEVICES (DEVICES)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_data_i      (cfg_data_i),
    .req_type_i      (s_axis_tuser),
    .device_index_i  (s_axis_tdata[2:0]),
    .enable_mode_i   (s_axis_tdata[4:3]),
    .channel_i       (s_axis_tdata[6:5]),
    .channel_value_i (s_axis_tdata[14:7]),
    .default_rgb_i   (s_axis_tdata[38:15]),
    .cmd_i           (cmd),
    .status_o        (status),
    .out_valid_o     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .out_device_o    (out_device),
    .out_red_o       (out_red),
    .out_green_o     (out_green),
    .out_blue_o      (out_blue),
    .out_last_o      (m_axis_tlast)
  );

  assign m_axis_tdata = {5'd0, out_blue, out_green, out_red, out_device};

  // The scan runs only while the input side is closed, so a tick can never
  // overlap a request that changes device state.
  a_ready_means_no_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !cmd.step_en)
    else $error("fade step while the input side is open");

endmodule

/* hdl/mlcf_ctrl.sv */
// Controller: accepts requests and sequences the per-device tick scan.
`timescale 1ns / 1ps

module mlcf_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_tick_i,
  input  mlcf_pkg::status_t status_i,
  output logic              in_ready_o,
  output mlcf_pkg::cmd_t    cmd_o
);
  import mlcf_pkg::*;

  state_e     state_q, state_d;
  logic [2:0] idx_q, idx_d;
  logic       advance;
  logic       at_last;

  assign advance = !status_i.cur_fading || status_i.out_free;
  assign at_last = ({1'b0, idx_q} == (status_i.n_active - 4'd1));

  // Next state.
  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && in_tick_i && (status_i.n_active != 4'd0)) begin
          state_d = ST_SCAN;
          idx_d   = 3'd0;
        end
      end
      ST_SCAN: begin
        if (advance) begin
          if (at_last) begin
            state_d = ST_IDLE;
          end else begin
            idx_d = idx_q + 3'd1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    in_ready_o      = 1'b0;
    cmd_o.apply_req = 1'b0;
    cmd_o.step_en   = 1'b0;
    cmd_o.idx       = idx_q;
    case (state_q)
      ST_IDLE: begin
        in_ready_o      = 1'b1;
        cmd_o.apply_req = in_valid_i && !in_tick_i;
      end
      ST_SCAN: begin
        cmd_o.step_en = status_i.cur_fading && status_i.out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= 3'd0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> ({1'b0, idx_q} < status_i.n_active))
    else $error("tick scan visits a device beyond the active count");

  a_tick_starts_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && in_valid_i && in_tick_i && status_i.n_active != 4'd0)
      |=> (state_q == ST_SCAN && idx_q == 3'd0))
    else $error("accepted tick did not start a scan at device zero");

  a_no_accept_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (!cmd_o.apply_req && !in_ready_o))
    else $error("request taken while a tick scan is running");

endmodule

/* hdl/mlcf_dp.sv */
// Datapath: per-device color state, request updates, fade step and output register.
`timescale 1ns / 1ps

module mlcf_dp #(
  parameter int DEVICES = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  input  logic [3:0]        cfg_data_i,
  input  logic [1:0]        req_type_i,
  input  logic [2:0]        device_index_i,
  input  logic [1:0]        enable_mode_i,
  input  logic [1:0]        channel_i,
  input  logic [7:0]        channel_value_i,
  input  logic [23:0]       default_rgb_i,
  input  mlcf_pkg::cmd_t    cmd_i,
  output mlcf_pkg::status_t status_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [2:0]        out_device_o,
  output logic [7:0]        out_red_o,
  output logic [7:0]        out_green_o,
  output logic [7:0]        out_blue_o,
  output logic              out_last_o
);
  import mlcf_pkg::*;

  localparam int IW = (DEVICES > 1) ? $clog2(DEVICES) : 1;

  logic [23:0] shown_q   [DEVICES];
  logic [23:0] shown_d   [DEVICES];
  logic [23:0] target_q  [DEVICES];
  logic [23:0] target_d  [DEVICES];
  logic [23:0] default_q [DEVICES];
  logic [23:0] default_d [DEVICES];
  logic [DEVICES-1:0] en_q, en_d;
  logic [DEVICES-1:0] fade_q, fade_d;
  logic [3:0]  count_q;
  logic [3:0]  n_active;

  logic        out_valid_q, out_valid_d;
  logic [2:0]  out_dev_q;
  logic [23:0] out_rgb_q;
  logic        out_last_q;

  logic [IW-1:0] ri;
  logic [IW-1:0] wi;
  logic [23:0]   step_end;
  logic [23:0]   step_cur;
  logic          more_fading;
  logic          sel_ok;
  logic [23:0]   new_target;
  logic          do_on, do_off;

  function automatic logic [7:0] step_chan(input logic [7:0] c, input logic [7:0] e);
    logic [7:0] r;
    r = c;
    if (c > e) r = c - 8'd1;
    else if (c < e) r = c + 8'd1;
    return r;
  endfunction

  assign n_active = (count_q > 4'(DEVICES)) ? 4'(DEVICES) : count_q;
  assign ri       = cmd_i.idx[IW-1:0];
  assign wi       = device_index_i[IW-1:0];
  assign sel_ok   = ({1'b0, device_index_i} < n_active);

  assign step_end = en_q[ri] ? target_q[ri] : 24'd0;
  assign step_cur = {step_chan(shown_q[ri][23:16], step_end[23:16]),
                     step_chan(shown_q[ri][15:8],  step_end[15:8]),
                     step_chan(shown_q[ri][7:0],   step_end[7:0])};

  // Any fading device after the one being stepped, within the active count.
  always_comb begin
    more_fading = 1'b0;
    for (int j = 0; j < DEVICES; j++) begin
      if ((4'(j) > {1'b0, cmd_i.idx}) && (4'(j) < n_active) && fade_q[j]) begin
        more_fading = 1'b1;
      end
    end
  end

  assign status_o.n_active   = n_active;
  assign status_o.cur_fading = fade_q[ri];
  assign status_o.out_free   = !out_valid_q || out_ready_i;

  // New target for a channel write.
  always_comb begin
    new_target = target_q[wi];
    case (channel_i)
      CH_RED:   new_target[23:16] = channel_value_i;
      CH_GREEN: new_target[15:8]  = channel_value_i;
      CH_BLUE:  new_target[7:0]   = channel_value_i;
      default:  ;
    endcase
  end

  always_comb begin
    do_on  = 1'b0;
    do_off = 1'b0;
    case (enable_mode_i)
      EN_OFF:  do_off = 1'b1;
      EN_ON:   do_on  = 1'b1;
      default: begin
        do_off = en_q[wi];
        do_on  = !en_q[wi];
      end
    endcase
  end

  always_comb begin
    shown_d   = shown_q;
    target_d  = target_q;
    default_d = default_q;
    en_d      = en_q;
    fade_d    = fade_q;
    if (cmd_i.apply_req && sel_ok) begin
      case (req_e'(req_type_i))
        REQ_ENABLE: begin
          if (do_on && !en_q[wi]) begin
            en_d[wi]   = 1'b1;
            fade_d[wi] = 1'b1;
            if (target_q[wi] == 24'd0) target_d[wi] = default_q[wi];
          end
          if (do_off && en_q[wi]) begin
            en_d[wi]   = 1'b0;
            fade_d[wi] = 1'b1;
          end
        end
        REQ_CHANNEL: begin
          if (channel_i != CH_NONE) begin
            target_d[wi] = new_target;
            en_d[wi]     = (new_target != 24'd0);
            fade_d[wi]   = 1'b1;
          end
        end
        REQ_DEFAULT: default_d[wi] = default_rgb_i;
        default: ;
      endcase
    end
    if (cmd_i.step_en) begin
      shown_d[ri] = step_cur;
      if (step_cur == step_end) fade_d[ri] = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.step_en) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < DEVICES; k++) begin
        shown_q[k]   <= 24'd0;
        target_q[k]  <= 24'd0;
        default_q[k] <= 24'd0;
      end
      en_q        <= '0;
      fade_q      <= '0;
      count_q     <= 4'd0;
      out_valid_q <= 1'b0;
    end else begin
      shown_q     <= shown_d;
      target_q    <= target_d;
      default_q   <= default_d;
      en_q        <= en_d;
      fade_q      <= fade_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) count_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step_en) begin
      out_dev_q  <= cmd_i.idx;
      out_rgb_q  <= step_cur;
      out_last_q <= !more_fading;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_device_o = out_dev_q;
  assign out_red_o    = out_rgb_q[23:16];
  assign out_green_o  = out_rgb_q[15:8];
  assign out_blue_o   = out_rgb_q[7:0];
  assign out_last_o   = out_last_q;

  a_step_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step_en |-> (status_o.out_free && fade_q[ri]))
    else $error("fade step issued without a free output slot");

  a_no_req_during_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.step_en && cmd_i.apply_req))
    else $error("request update collides with a fade step");

endmodule

/* verif/tb.sv */
// Self-checking testbench for the multi-LED color fader core.
`timescale 1ns / 1ps

module tb;
  import mlcf_pkg::*;

  localparam int DEVICES        = 8;
  localparam int RESET_CYCLES   = 6;
  localparam int SETTLE_CYCLES  = 24;
  localparam int HOLDOFF_CYCLES = 400;
  localparam int LIMIT_CYCLES   = 200000;

  // Toggle codes, named here for the stimulus.
  localparam logic [1:0] EN_TOGGLE     = 2'd2;
  localparam logic [1:0] EN_TOGGLE_ALT = 2'd3;

  typedef logic [23:0] rgb_t;

  typedef struct packed {
    req_e       kind;
    logic [2:0] dev;
    logic [1:0] mode;
    logic [1:0] chan;
    logic [7:0] value;
    rgb_t       rgb;
  } fader_req_t;

  typedef struct packed {
    logic [2:0] dev;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
  } color_beat_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic [3:0]  cfg_data_i    = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata  = '0;
  logic [1:0]  s_axis_tuser  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tlast;

  multi_led_color_fader_core #(
    .DEVICES(DEVICES)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Shadow copy of the fader state, advanced on every accepted beat.
  rgb_t       shown_m   [DEVICES] = '{default: '0};
  rgb_t       target_m  [DEVICES] = '{default: '0};
  rgb_t       default_m [DEVICES] = '{default: '0};
  logic       enabled_m [DEVICES] = '{default: 1'b0};
  logic       fading_m  [DEVICES] = '{default: 1'b0};
  logic [3:0] dev_count = '0;

  fader_req_t  pending_reqs[$];
  color_beat_t expected_colors[$];

  int unsigned error_count  = 0;
  int unsigned req_beats    = 0;
  int unsigned tick_beats   = 0;
  int unsigned color_beats  = 0;
  int unsigned count_writes = 0;
  int unsigned cycle_count  = 0;

  // Knobs the sequence changes per phase.
  int unsigned stall_mode = 0;
  logic        gaps_on    = 1'b0;
  int unsigned holdoff_req = 0;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
    error_count++;
  endtask

  // One step of every channel toward its end value.
  function automatic rgb_t step_rgb(input rgb_t cur, input rgb_t dst);
    rgb_t res;
    logic [7:0] c;
    logic [7:0] e;
    res = '0;
    for (int k = 0; k < 3; k++) begin
      c = cur[8*k +: 8];
      e = dst[8*k +: 8];
      if (c > e) c = c - 8'd1;
      else if (c < e) c = c + 8'd1;
      res[8*k +: 8] = c;
    end
    return res;
  endfunction

  // Applies one request to the shadow state and queues the colors a tick reports.
  task automatic fader_apply(input fader_req_t rq);
    int unsigned n_act;
    rgb_t        dst;
    logic        want_on;
    color_beat_t beat;
    color_beat_t batch[$];
    n_act = (dev_count > DEVICES) ? DEVICES : dev_count;
    if (rq.kind == REQ_TICK) begin
      for (int unsigned i = 0; i < n_act; i++) begin
        if (!fading_m[i]) continue;
        dst = enabled_m[i] ? target_m[i] : '0;
        shown_m[i] = step_rgb(shown_m[i], dst);
        if (shown_m[i] == dst) fading_m[i] = 1'b0;
        beat.dev   = 3'(i);
        beat.red   = shown_m[i][23:16];
        beat.green = shown_m[i][15:8];
        beat.blue  = shown_m[i][7:0];
        beat.last  = 1'b0;
        batch.push_back(beat);
      end
      foreach (batch[k]) begin
        beat = batch[k];
        beat.last = (k == batch.size() - 1);
        expected_colors.push_back(beat);
      end
    end else if (rq.dev < n_act) begin
      case (rq.kind)
        REQ_ENABLE: begin
          if (rq.mode == EN_OFF) want_on = 1'b0;
          else if (rq.mode == EN_ON) want_on = 1'b1;
          else want_on = !enabled_m[rq.dev];
          // Asking for the state the device is already in changes nothing.
          if (want_on != enabled_m[rq.dev]) begin
            enabled_m[rq.dev] = want_on;
            if (want_on && target_m[rq.dev] == '0) target_m[rq.dev] = default_m[rq.dev];
            fading_m[rq.dev] = 1'b1;
          end
        end
        REQ_CHANNEL: begin
          if (rq.chan != CH_NONE) begin
            case (rq.chan)
              CH_RED:   target_m[rq.dev][23:16] = rq.value;
              CH_GREEN: target_m[rq.dev][15:8]  = rq.value;
              default:  target_m[rq.dev][7:0]   = rq.value;
            endcase
            enabled_m[rq.dev] = (target_m[rq.dev] != '0);
            fading_m[rq.dev]  = 1'b1;
          end
        end
        default: default_m[rq.dev] = rq.rgb;
      endcase
    end
  endtask

  // Sender: bursts of random length, optionally separated by random gaps.
  fader_req_t  drv_req;
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (gap_left > 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        drv_req = pending_reqs.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, drv_req.rgb, drv_req.value, drv_req.chan, drv_req.mode,
                          drv_req.dev};
        s_axis_tuser  <= drv_req.kind;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 16);
          if (gaps_on) gap_left = $urandom_range(1, 8);
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: a per-phase stall pattern, plus a long hold-off on request.
  int unsigned holdoff_seen = 0;
  int unsigned holdoff_left = 0;
  int unsigned stall_phase  = 0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      stall_phase++;
      if (holdoff_req != holdoff_seen) begin
        holdoff_seen = holdoff_req;
        holdoff_left = HOLDOFF_CYCLES;
      end
      if (holdoff_left > 0) begin
        holdoff_left--;
        m_axis_tready <= 1'b0;
      end else begin
        case (stall_mode)
          0:       m_axis_tready <= 1'b1;
          1:       m_axis_tready <= ($urandom_range(0, 99) < 75);
          2:       m_axis_tready <= ($urandom_range(0, 99) < 30);
          default: m_axis_tready <= ((stall_phase % 5) < 3);
        endcase
      end
    end
  end

  // Monitor: predicts on accepted requests and checks every accepted color beat.
  fader_req_t  mon_req;
  color_beat_t want_beat;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        dev_count = cfg_data_i;
        count_writes++;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        mon_req.kind  = req_e'(s_axis_tuser);
        mon_req.dev   = s_axis_tdata[2:0];
        mon_req.mode  = s_axis_tdata[4:3];
        mon_req.chan  = s_axis_tdata[6:5];
        mon_req.value = s_axis_tdata[14:7];
        mon_req.rgb   = s_axis_tdata[38:15];
        req_beats++;
        if (mon_req.kind == REQ_TICK) tick_beats++;
        fader_apply(mon_req);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        color_beats++;
        if (expected_colors.size() == 0) begin
          report_mismatch("color beat with nothing pending, device", m_axis_tdata[2:0], -1);
        end else begin
          want_beat = expected_colors.pop_front();
          if (m_axis_tdata[2:0] != want_beat.dev)
            report_mismatch("out_device", m_axis_tdata[2:0], want_beat.dev);
          if (m_axis_tdata[10:3] != want_beat.red)
            report_mismatch("out_red", m_axis_tdata[10:3], want_beat.red);
          if (m_axis_tdata[18:11] != want_beat.green)
            report_mismatch("out_green", m_axis_tdata[18:11], want_beat.green);
          if (m_axis_tdata[26:19] != want_beat.blue)
            report_mismatch("out_blue", m_axis_tdata[26:19], want_beat.blue);
          if (m_axis_tlast != want_beat.last)
            report_mismatch("out_last", m_axis_tlast, want_beat.last);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles with %0d color beats pending",
               cycle_count, expected_colors.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic void push_req(input req_e kind, input logic [2:0] dev,
                                   input logic [1:0] mode, input logic [1:0] chan,
                                   input logic [7:0] value, input rgb_t rgb);
    fader_req_t rq;
    rq.kind  = kind;
    rq.dev   = dev;
    rq.mode  = mode;
    rq.chan  = chan;
    rq.value = value;
    rq.rgb   = rgb;
    pending_reqs.push_back(rq);
  endfunction

  // Tiny intensities half of the time, so fades finish within a few ticks.
  function automatic logic [7:0] rand_level();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 5) return 8'($urandom_range(0, 4));
    if (pick == 5) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic fader_req_t rand_request(input int unsigned n_act);
    fader_req_t  rq;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 40) rq.kind = REQ_TICK;
    else if (pick < 70) rq.kind = REQ_CHANNEL;
    else if (pick < 88) rq.kind = REQ_ENABLE;
    else rq.kind = REQ_DEFAULT;
    if (n_act > DEVICES) n_act = DEVICES;
    // Most requests address a live device; the rest may fall out of range.
    if (n_act > 0 && $urandom_range(0, 99) < 85) rq.dev = 3'($urandom_range(0, n_act - 1));
    else rq.dev = 3'($urandom_range(0, 7));
    rq.mode  = 2'($urandom_range(0, 3));
    rq.chan  = ($urandom_range(0, 9) == 0) ? CH_NONE : 2'($urandom_range(0, 2));
    rq.value = rand_level();
    if ($urandom_range(0, 1) == 0) rq.rgb = {rand_level(), rand_level(), rand_level()};
    else rq.rgb = 24'($urandom);
    return rq;
  endfunction

  task automatic queue_random(input int unsigned cnt, input int unsigned n_act);
    for (int unsigned i = 0; i < cnt; i++) pending_reqs.push_back(rand_request(n_act));
  endtask

  task automatic write_count(input logic [3:0] cnt);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= cnt;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  // Waits until every request is taken and every color beat is checked, then
  // lets a tick scan that reports nothing run out.
  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_reqs.size() != 0 || s_axis_tvalid || expected_colors.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic run_phase(input logic [3:0] cnt, input int unsigned stall,
                           input logic gaps, input int unsigned n_items);
    stall_mode = stall;
    gaps_on    = gaps;
    write_count(cnt);
    queue_random(n_items, cnt);
    wait_drained();
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Full device count: enable paths, defaults and channel writes.
    stall_mode = 0;
    gaps_on    = 1'b0;
    write_count(4'd8);
    @(negedge clk_i);
    push_req(REQ_TICK,    3'd0, EN_OFF,        CH_RED,   8'h00, 24'h000000);
    push_req(REQ_DEFAULT, 3'd0, EN_OFF,        CH_RED,   8'h00, 24'hFFFFFF);
    push_req(REQ_ENABLE,  3'd0, EN_ON,         CH_RED,   8'h00, 24'h000000);
    push_req(REQ_ENABLE,  3'd0, EN_ON,         CH_RED,   8'h00, 24'h000000);
    push_req(REQ_TICK,    3'd0, EN_OFF,        CH_RED,   8'h00, 24'h000000);
    // Enabling with a black target and a black default still starts a fade.
    push_req(REQ_ENABLE,  3'd1, EN_ON,         CH_RED,   8'h00, 24'h000000);
    push_req(REQ_TICK,    3'd0, EN_OFF,        CH_RED,   8'h00, 24'h000000);
    push_req(REQ_CHANNEL, 3'd2, EN_OFF,        CH_BLUE,  8'hFF, 24'h000000);
    push_req(REQ_CHANNEL, 3'd2, EN_OFF,        CH_NONE,  8'h55, 24'h000000);
    push_req(REQ_CHANNEL, 3'd3, EN_OFF,        CH_GREEN, 8'h01, 24'h000000);
    push_req(REQ_CHANNEL, 3'd7, EN_OFF,        CH_RED,   8'h00, 24'hFFFFFF);
    push_req(REQ_ENABLE,  3'd0, EN_TOGGLE_ALT, CH_RED,   8'h00, 24'h000000);
    push_req(REQ_ENABLE,  3'd4, EN_OFF,        CH_RED,   8'h00, 24'h000000);
    push_req(REQ_TICK,    3'd7, EN_OFF,        CH_RED,   8'h00, 24'h000000);
    push_req(REQ_ENABLE,  3'd2, EN_TOGGLE,     CH_RED,   8'h00, 24'h000000);
    push_req(REQ_DEFAULT, 3'd5, EN_OFF,        CH_RED,   8'h00, 24'h123456);
    push_req(REQ_TICK,    3'd0, EN_OFF,        CH_RED,   8'h00, 24'h000000);
    push_req(REQ_TICK,    3'd0, EN_OFF,        CH_RED,   8'h00, 24'h000000);
    wait_drained();

    // The receiver holds off while all eight devices fade and ticks keep
    // arriving, so the output register fills and the input stalls.
    holdoff_req++;
    for (int unsigned d = 0; d < DEVICES; d++)
      push_req(REQ_CHANNEL, 3'(d), EN_OFF, 2'($urandom_range(0, 2)),
               8'($urandom_range(1, 255)), 24'h000000);
    repeat (4) push_req(REQ_TICK, 3'd0, EN_OFF, CH_RED, 8'h00, 24'h000000);
    wait_drained();

    stall_mode = 1;
    gaps_on    = 1'b1;
    queue_random(30, 8);
    wait_drained();

    // Shrunk count: devices three and up keep their state but are skipped.
    stall_mode = 3;
    write_count(4'd3);
    @(negedge clk_i);
    push_req(REQ_CHANNEL, 3'd5, EN_OFF, CH_RED, 8'hFF, 24'h000000);
    push_req(REQ_ENABLE,  3'd7, EN_ON,  CH_RED, 8'h00, 24'h000000);
    push_req(REQ_TICK,    3'd0, EN_OFF, CH_RED, 8'h00, 24'h000000);
    queue_random(28, 3);
    wait_drained();

    // A count above the device number acts as the full set.
    run_phase(4'd15, 2, 1'b0, 28);

    // No active device: everything is ignored and ticks report nothing.
    stall_mode = 0;
    write_count(4'd0);
    @(negedge clk_i);
    push_req(REQ_CHANNEL, 3'd0, EN_OFF, CH_GREEN, 8'h80, 24'h000000);
    push_req(REQ_TICK,    3'd0, EN_OFF, CH_RED,   8'h00, 24'h000000);
    wait_drained();

    run_phase(4'd1, 1, 1'b1, 13);
    run_phase(4'd5, 3, 1'b1, 13);
    run_phase(4'd8, 2, 1'b1, 13);

    if (expected_colors.size() != 0)
      report_mismatch("color beats never delivered", 0, expected_colors.size());
    $display("Ran %0d request beats (%0d ticks) across %0d device-count settings.",
             req_beats, tick_beats, count_writes);
    $display("Checked %0d color beats, including a %0d-cycle output hold-off.",
             color_beats, HOLDOFF_CYCLES);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* multi_led_color_fader_core.f */
hdl/mlcf_pkg.sv
hdl/mlcf_ctrl.sv
hdl/mlcf_dp.sv
hdl/multi_led_color_fader_core.sv
verif/tb.sv
